// ===== rtl/core/pxc_pkg.sv =====
// shared types and constants for the polyline proximity check
// no dependencies; used by every module of the block
package pxc_pkg;

    localparam int CoordW  = 24;
    localparam int DiffW   = CoordW + 1;
    localparam int ProdW   = 2 * DiffW;
    localparam int DotW    = ProdW + 1;
    localparam int SqW     = ProdW;
    localparam int HalfW   = DiffW;
    localparam int MaxSqW  = 2 * CoordW;
    localparam int MHalfW  = CoordW;
    localparam int WideW   = 2 * SqW;
    localparam int ApbW    = 32;
    localparam int ApbAddrW = 2;

    localparam logic [CoordW-1:0] MAX_DIST_RESET = CoordW'(1000);
    localparam logic [MaxSqW-1:0] MAX_SQ_RESET   = MaxSqW'(1000000);

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;

    typedef struct packed {
        logic  first;
        logic  last;
        t_diff dx;
        t_diff dy;
        t_diff wx;
        t_diff wy;
        t_diff ex;
        t_diff ey;
    } t_work;

    typedef struct packed {
        logic push;
        logic violation;
    } t_res;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_SUM,
        BK_MUL2,
        BK_ADD,
        BK_DONE
    } t_back_state;

    function automatic t_prod smul(input t_diff a, input t_diff b);
        t_prod ae;
        t_prod be;
        ae = ProdW'(a);
        be = ProdW'(b);
        return ae * be;
    endfunction

endpackage

// ===== rtl/core/pxc_front.sv =====
// front end: accepts path points and forms segment differences
// depends on pxc_pkg
module pxc_front
    import pxc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_q_full,
    input  t_coord i_robot_x,
    input  t_coord i_robot_y,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  logic   i_first_point,
    input  logic   i_last_point,
    output logic   o_q_push,
    output t_work  o_q_data
);

    t_coord r_prev_x;
    t_coord r_prev_y;
    t_coord start_x;
    t_coord start_y;
    logic   single;

    assign o_q_push = i_push && !i_q_full;

    // a one-point path is a zero-length segment at that point
    assign single  = i_first_point && i_last_point;
    assign start_x = single ? i_point_x : r_prev_x;
    assign start_y = single ? i_point_y : r_prev_y;

    always_comb begin
        o_q_data.first = i_first_point;
        o_q_data.last  = i_last_point;
        o_q_data.dx    = DiffW'(i_point_x) - DiffW'(start_x);
        o_q_data.dy    = DiffW'(i_point_y) - DiffW'(start_y);
        o_q_data.wx    = DiffW'(i_robot_x) - DiffW'(start_x);
        o_q_data.wy    = DiffW'(i_robot_y) - DiffW'(start_y);
        o_q_data.ex    = DiffW'(i_robot_x) - DiffW'(i_point_x);
        o_q_data.ey    = DiffW'(i_robot_y) - DiffW'(i_point_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (o_q_push) begin
            r_prev_x <= i_point_x;
            r_prev_y <= i_point_y;
        end
    end

endmodule

// ===== rtl/core/pxc_queue.sv =====
// short queue of classified work between front and back end
// depends on pxc_pkg
module pxc_queue
    import pxc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_work           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/pxc_back.sv =====
// back end: squared distance tests, path flag and result generation
// depends on pxc_pkg
module pxc_back
    import pxc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_work             i_q_data,
    output logic              o_q_pop,
    input  logic [MaxSqW-1:0] i_max_sq,
    input  logic              i_res_ready,
    output t_res              o_res
);

    t_back_state r_state;
    t_back_state n_state;

    t_work r_work;
    logic  r_found;
    logic  n_found;
    logic  finish;
    logic  near;

    t_prod r_p_wxdx, r_p_wydy, r_p_dxdx, r_p_dydy, r_p_dxwy, r_p_dywx;
    t_prod r_p_wxwx, r_p_wywy, r_p_exex, r_p_eyey;

    logic signed [DotW-1:0] r_t;
    logic [SqW-1:0]         r_den;
    logic [SqW-1:0]         r_cross;
    logic [SqW-1:0]         r_dw;
    logic [SqW-1:0]         r_de;
    logic signed [DotW-1:0] cross_s;
    logic signed [DotW-1:0] den_s;
    logic signed [DotW-1:0] dw_s;
    logic signed [DotW-1:0] de_s;
    logic signed [DotW-1:0] cross_abs;

    logic [ProdW-1:0] r_c_hh, r_c_hl, r_c_ll;
    logic [ProdW-1:0] r_m_hh, r_m_hl, r_m_lh, r_m_ll;
    logic [WideW-1:0] r_lhs;
    logic [WideW-1:0] r_rhs;
    logic             r_mid;
    logic             r_near_pt;
    logic             t_pos;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_MUL1;
            BK_MUL1: n_state = BK_SUM;
            BK_SUM:  n_state = BK_MUL2;
            BK_MUL2: n_state = BK_ADD;
            BK_ADD:  n_state = BK_DONE;
            BK_DONE: begin
                if (finish) begin
                    n_state = i_q_empty ? BK_IDLE : BK_MUL1;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    assign finish = !(r_work.last && !i_res_ready);
    assign near   = r_mid ? (r_lhs < r_rhs) : r_near_pt;
    assign n_found = (r_work.first ? 1'b0 : r_found)
                   | ((!r_work.first || r_work.last) && near);

    always_comb begin
        o_q_pop       = 1'b0;
        o_res.push    = 1'b0;
        o_res.violation = !n_found;
        unique case (r_state)
            BK_IDLE: o_q_pop = !i_q_empty;
            BK_DONE: begin
                o_q_pop    = finish && !i_q_empty;
                o_res.push = finish && r_work.last;
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_DONE && finish) begin
                r_found <= n_found;
            end
        end
    end

    // datapath
    assign cross_s   = DotW'(r_p_dxwy) - DotW'(r_p_dywx);
    assign den_s     = DotW'(r_p_dxdx) + DotW'(r_p_dydy);
    assign dw_s      = DotW'(r_p_wxwx) + DotW'(r_p_wywy);
    assign de_s      = DotW'(r_p_exex) + DotW'(r_p_eyey);
    assign cross_abs = cross_s[DotW-1] ? -cross_s : cross_s;
    assign t_pos     = !r_t[DotW-1] && (r_t != '0);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_work <= i_q_data;
        end
        if (r_state == BK_MUL1) begin
            r_p_wxdx <= smul(r_work.wx, r_work.dx);
            r_p_wydy <= smul(r_work.wy, r_work.dy);
            r_p_dxdx <= smul(r_work.dx, r_work.dx);
            r_p_dydy <= smul(r_work.dy, r_work.dy);
            r_p_dxwy <= smul(r_work.dx, r_work.wy);
            r_p_dywx <= smul(r_work.dy, r_work.wx);
            r_p_wxwx <= smul(r_work.wx, r_work.wx);
            r_p_wywy <= smul(r_work.wy, r_work.wy);
            r_p_exex <= smul(r_work.ex, r_work.ex);
            r_p_eyey <= smul(r_work.ey, r_work.ey);
        end
        if (r_state == BK_SUM) begin
            r_t     <= DotW'(r_p_wxdx) + DotW'(r_p_wydy);
            r_den   <= den_s[SqW-1:0];
            r_dw    <= dw_s[SqW-1:0];
            r_de    <= de_s[SqW-1:0];
            r_cross <= cross_abs[SqW-1:0];
        end
        if (r_state == BK_MUL2) begin
            // split products so each multiplier stays near 25 bits
            r_c_hh <= ProdW'(r_cross[SqW-1:HalfW]) * ProdW'(r_cross[SqW-1:HalfW]);
            r_c_hl <= ProdW'(r_cross[SqW-1:HalfW]) * ProdW'(r_cross[HalfW-1:0]);
            r_c_ll <= ProdW'(r_cross[HalfW-1:0]) * ProdW'(r_cross[HalfW-1:0]);
            r_m_hh <= ProdW'(i_max_sq[MaxSqW-1:MHalfW]) * ProdW'(r_den[SqW-1:HalfW]);
            r_m_hl <= ProdW'(i_max_sq[MaxSqW-1:MHalfW]) * ProdW'(r_den[HalfW-1:0]);
            r_m_lh <= ProdW'(i_max_sq[MHalfW-1:0]) * ProdW'(r_den[SqW-1:HalfW]);
            r_m_ll <= ProdW'(i_max_sq[MHalfW-1:0]) * ProdW'(r_den[HalfW-1:0]);
        end
        if (r_state == BK_ADD) begin
            r_lhs <= (WideW'(r_c_hh) << (2 * HalfW)) + (WideW'(r_c_hl) << (HalfW + 1))
                   + WideW'(r_c_ll);
            r_rhs <= (WideW'(r_m_hh) << (MHalfW + HalfW)) + (WideW'(r_m_hl) << MHalfW)
                   + (WideW'(r_m_lh) << HalfW) + WideW'(r_m_ll);
            r_near_pt <= t_pos ? (r_de < SqW'(i_max_sq)) : (r_dw < SqW'(i_max_sq));
            r_mid     <= t_pos && (r_t[SqW-1:0] < r_den);
        end
    end

endmodule

// ===== rtl/core/polyline_proximity_check.sv =====
// top level of the polyline proximity check: config register, result stage
// depends on pxc_pkg, pxc_front, pxc_queue, pxc_back
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  points in | push / full          | i_robot_x/y, i_point_x/y, i_first/last_point
//  results   | empty / pop          | o_violation
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always high)
//
// the back end steps each point through multiply, sum, multiply, wide add and
// compare; a new point is taken every cycle until QUEUE_DEPTH points wait
// with nothing ahead, a result shows once its last point has passed the queue,
// the back end and the result register, later while earlier points are still
// queued; a held result stalls the back end only if another is ready behind it
// synchronous reset sets max_distance to 1000 and clears the path state
module polyline_proximity_check
    import pxc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbW-1:0]     pwdata,
    output logic [ApbW-1:0]     prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  t_coord              i_robot_x,
    input  t_coord              i_robot_y,
    input  t_coord              i_point_x,
    input  t_coord              i_point_y,
    input  logic                i_first_point,
    input  logic                i_last_point,
    output logic                empty,
    input  logic                pop,
    output logic                o_violation
);

    logic [CoordW-1:0] r_max_dist;
    logic [MaxSqW-1:0] r_max_sq;
    logic              cfg_wr;
    logic              q_push;
    t_work             q_wdata;
    logic              q_full;
    logic              q_pop;
    t_work             q_rdata;
    logic              q_empty;
    t_res              res;
    logic              res_ready;
    logic              r_res_valid;
    logic              r_res_viol;

    // single register: every address maps to max_distance
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {{(ApbW - CoordW - ApbAddrW){1'b0}}, paddr & '0, r_max_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RESET;
            r_max_sq   <= MAX_SQ_RESET;
        end else if (cfg_wr) begin
            r_max_dist <= pwdata[CoordW-1:0];
            r_max_sq   <= MaxSqW'(pwdata[CoordW-1:0]) * MaxSqW'(pwdata[CoordW-1:0]);
        end
    end

    pxc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_robot_x     (i_robot_x),
        .i_robot_y     (i_robot_y),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_first_point (i_first_point),
        .i_last_point  (i_last_point),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    pxc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    pxc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_max_sq    (r_max_sq),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign full        = q_full;
    assign res_ready   = !r_res_valid || pop;
    assign empty       = !r_res_valid;
    assign o_violation = r_res_viol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res.push) begin
            r_res_valid <= 1'b1;
        end else if (pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.push) begin
            r_res_viol <= res.violation;
        end
    end

endmodule

// ===== rtl/core/pxc_checker.sv =====
// port-level checks for the polyline proximity check, bound to the top level
// depends on pxc_pkg and polyline_proximity_check
module pxc_checker
    import pxc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic                pready,
    input logic [ApbW-1:0]     pwdata,
    input logic [ApbW-1:0]     prdata,
    input logic                empty,
    input logic                pop,
    input logic                o_violation
);

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result dropped without transfer");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_violation))
        else $error("waiting result changed");

    a_reset_limit: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> prdata == ApbW'(MAX_DIST_RESET))
        else $error("max_distance not at reset value");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> empty)
        else $error("result shown right after reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready |=>
            prdata == ApbW'($past(pwdata[CoordW-1:0])))
        else $error("max_distance readback mismatch");

endmodule

bind polyline_proximity_check pxc_checker u_pxc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .empty       (empty),
    .pop         (pop),
    .o_violation (o_violation)
);

// ===== verif/polyline_proximity_check_tb.sv =====
// self-checking testbench for polyline_proximity_check: directed and random paths
// with random idling on both sides, an own path-distance predictor and an apb port driver
// depends on pxc_pkg and the polyline_proximity_check rtl
module polyline_proximity_check_tb;
    import pxc_pkg::*;

    localparam logic [ApbAddrW-1:0] MAX_DIST_ADDR = ApbAddrW'(0);
    localparam logic [CoordW-1:0]   LIMIT_TOP     = '1;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_coord robot_x;
        t_coord robot_y;
        t_coord point_x;
        t_coord point_y;
        logic   first;
        logic   last;
    } t_path_point;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbW-1:0]     pwdata;
    logic [ApbW-1:0]     prdata;
    logic                pready;
    logic                push;
    logic                full;
    t_coord              i_robot_x;
    t_coord              i_robot_y;
    t_coord              i_point_x;
    t_coord              i_point_y;
    logic                i_first_point;
    logic                i_last_point;
    logic                empty;
    logic                pop;
    logic                o_violation;

    // predictor state
    logic [CoordW-1:0] dist_limit;
    t_coord            prev_x;
    t_coord            prev_y;
    bit                near_seen;
    bit                verdict_q[$];

    bit idle_on;
    int stall_left;
    int quiet_cycles;
    int error_count;
    int points_sent;
    int verdicts_checked;
    int limit_writes;
    bit expected_violation;

    polyline_proximity_check dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("error at %0t: %s", $time, msg);
    endfunction

    function automatic bit within_reach(input longint ex, input longint ey);
        longint d2;
        longint lim;
        d2  = ex * ex + ey * ey;
        lim = longint'(dist_limit);
        return d2 < lim * lim;
    endfunction

    function automatic bit segment_reach(input longint rx, input longint ry,
                                         input longint x0, input longint y0,
                                         input longint x1, input longint y1);
        longint dx, dy, wx, wy, t, den, cr;
        logic [127:0] c_w, m_w, d_w;
        dx  = x1 - x0;
        dy  = y1 - y0;
        wx  = rx - x0;
        wy  = ry - y0;
        t   = wx * dx + wy * dy;
        den = dx * dx + dy * dy;
        if (t <= 0)
            return within_reach(wx, wy);
        if (t >= den)
            return within_reach(rx - x1, ry - y1);
        cr = dx * wy - dy * wx;
        if (cr < 0)
            cr = -cr;
        c_w = 128'(cr);
        m_w = 128'(dist_limit);
        d_w = 128'(den);
        return (c_w * c_w) < (m_w * m_w * d_w);
    endfunction

    function automatic void advance_path(input t_path_point p);
        longint rx, ry, px, py;
        rx = p.robot_x;
        ry = p.robot_y;
        px = p.point_x;
        py = p.point_y;
        if (p.first)
            near_seen = p.last ? within_reach(rx - px, ry - py) : 1'b0;
        else if (segment_reach(rx, ry, prev_x, prev_y, px, py))
            near_seen = 1'b1;
        prev_x = p.point_x;
        prev_y = p.point_y;
        if (p.last)
            verdict_q.push_back(!near_seen);
    endfunction

    function automatic t_coord fit_coord(input longint v);
        if (v > 8388607)
            return t_coord'(8388607);
        if (v < -8388608)
            return t_coord'(-8388608);
        return t_coord'(v);
    endfunction

    function automatic longint jitter(input longint s);
        return longint'($urandom_range(0, int'(2 * s))) - s;
    endfunction

    function automatic logic [CoordW-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LIMIT_TOP;
            2, 3: return CoordW'($urandom);
            default: return CoordW'($urandom_range(1, 4000));
        endcase
    endfunction

    // one point transfer, with an optional idle burst in front
    task automatic send_point(input t_path_point p);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_robot_x     <= p.robot_x;
        i_robot_y     <= p.robot_y;
        i_point_x     <= p.point_x;
        i_point_y     <= p.point_y;
        i_first_point <= p.first;
        i_last_point  <= p.last;
        do @(posedge i_clk); while (full);
        advance_path(p);
        points_sent++;
    endtask

    task automatic send_xy(input longint rx, input longint ry, input longint px,
                           input longint py, input bit first, input bit last);
        t_path_point p;
        p.robot_x = fit_coord(rx);
        p.robot_y = fit_coord(ry);
        p.point_x = fit_coord(px);
        p.point_y = fit_coord(py);
        p.first   = first;
        p.last    = last;
        send_point(p);
    endtask

    task automatic send_path(input int len);
        t_path_point p;
        longint span, reach, cx, cy, bx, by;
        bit roam, skip_first, skip_last;
        int i;
        span       = longint'(1) << $urandom_range(0, 23);
        reach      = longint'(1) << $urandom_range(0, 23);
        cx         = t_coord'($urandom);
        cy         = t_coord'($urandom);
        bx         = fit_coord(cx + jitter(reach));
        by         = fit_coord(cy + jitter(reach));
        roam       = ($urandom_range(0, 4) == 0);
        skip_first = ($urandom_range(0, 11) == 0);
        skip_last  = ($urandom_range(0, 11) == 0);
        for (i = 0; i < len; i++) begin
            if (roam) begin
                bx = fit_coord(bx + jitter(reach));
                by = fit_coord(by + jitter(reach));
            end
            p.robot_x = fit_coord(bx);
            p.robot_y = fit_coord(by);
            p.point_x = fit_coord(cx);
            p.point_y = fit_coord(cy);
            p.first   = (i == 0) && !skip_first;
            p.last    = (i == len - 1) && !skip_last;
            send_point(p);
            cx = fit_coord(cx + jitter(span));
            cy = fit_coord(cy + jitter(span));
        end
    endtask

    task automatic send_noise();
        t_path_point p;
        p.robot_x = t_coord'($urandom);
        p.robot_y = t_coord'($urandom);
        p.point_x = t_coord'($urandom);
        p.point_y = t_coord'($urandom);
        p.first   = $urandom_range(0, 1);
        p.last    = $urandom_range(0, 1);
        send_point(p);
    endtask

    task automatic send_random_traffic(input int n_items);
        int start;
        start = points_sent;
        while (points_sent - start < n_items) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else if ($urandom_range(0, 4) == 0)
                send_path($urandom_range(7, 24));
            else
                send_path($urandom_range(1, 6));
        end
    endtask

    // hold the sender until every expected verdict is out and the pipe is empty
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_limit_check(input logic [CoordW-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_DIST_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== ApbW'(want))
            flag_error($sformatf("max_distance readback: expected %0d, got %0d", want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_limit(input logic [CoordW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_DIST_ADDR;
        pwdata  <= ApbW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dist_limit = value;
        limit_writes++;
        read_limit_check(value);
    endtask

    task automatic test_orphan_points();
        // segment from the reset origin, then a continuation after a last point
        send_xy(500, 300, 2000, 0, 1'b0, 1'b0);
        send_xy(0, 5000, 2000, 3000, 1'b0, 1'b1);
        send_xy(9000, 9000, 2500, 3000, 1'b0, 1'b1);
    endtask

    task automatic test_single_points();
        send_xy(100, 100, 100, 100, 1'b1, 1'b1);
        send_xy(0, 0, 600, 800, 1'b1, 1'b1);
        send_xy(0, 0, 599, 800, 1'b1, 1'b1);
        send_xy(-8388608, -8388608, 8388607, 8388607, 1'b1, 1'b1);
        send_xy(8388607, -8388608, 8388607, -8388608, 1'b1, 1'b1);
    endtask

    task automatic test_segment_cases();
        // zero-length segment at the limit, then a point behind the start
        send_xy(5000, 5000, 0, 0, 1'b1, 1'b0);
        send_xy(0, 1000, 0, 0, 1'b0, 1'b0);
        send_xy(-999, 0, 10000, 0, 1'b0, 1'b1);
        // past the end and beside the middle, both exactly at the limit
        send_xy(0, 0, 0, 0, 1'b1, 1'b0);
        send_xy(11000, 0, 10000, 0, 1'b0, 1'b0);
        send_xy(9000, 5000, 10000, 10000, 1'b0, 1'b1);
        // full-range diagonal
        send_xy(8388607, 8388607, -8388608, -8388608, 1'b1, 1'b0);
        send_xy(-8388608, 8388607, 8388607, 8388607, 1'b0, 1'b1);
        // beside the middle, inside
        send_xy(0, 0, 0, 0, 1'b1, 1'b0);
        send_xy(5000, 5999, 10000, 10000, 1'b0, 1'b1);
    endtask

    task automatic test_limit_extremes();
        logic [CoordW-1:0] limits[3];
        int i;
        int start;
        limits[0] = '0;
        limits[1] = LIMIT_TOP;
        limits[2] = CoordW'(1);
        for (i = 0; i < 3; i++) begin
            wait_drained();
            write_limit(limits[i]);
            start = points_sent;
            send_xy(-42, 77, -42, 77, 1'b1, 1'b1);
            send_xy(0, 0, -8388608, -8388608, 1'b1, 1'b0);
            send_xy(-8388608, 8388607, 8388607, 8388607, 1'b0, 1'b1);
            send_random_traffic(35 - (points_sent - start));
        end
    endtask

    task automatic test_random_paths(input int n_items);
        int start;
        start = points_sent;
        while (points_sent - start < n_items) begin
            wait_drained();
            write_limit(pick_limit());
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_traffic(60);
            idle_on = 1'b1;
            send_random_traffic(60);
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        wait_drained();
        write_limit(CoordW'($urandom_range(500, 3000)));
        idle_on = 1'b0;
        send_random_traffic(n_items);
    endtask

    // result side: pop with random stall bursts while idle_on is set
    always @(negedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            pop <= 1'b1;
        end
    end

    // verdict check on every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("unexpected verdict %b", o_violation));
            end else begin
                expected_violation = verdict_q.pop_front();
                verdicts_checked++;
                if (o_violation !== expected_violation)
                    flag_error($sformatf("violation: expected %b, got %b",
                                         expected_violation, o_violation));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d verdicts outstanding",
                     quiet_cycles, verdict_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        pop           = 1'b0;
        i_robot_x     = '0;
        i_robot_y     = '0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_first_point = 1'b0;
        i_last_point  = 1'b0;
        dist_limit    = MAX_DIST_RESET;
        prev_x        = '0;
        prev_y        = '0;
        near_seen     = 1'b0;
        idle_on       = 1'b1;
        stall_left    = 0;
        quiet_cycles  = 0;
        error_count   = 0;
        points_sent   = 0;
        verdicts_checked = 0;
        limit_writes  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_limit_check(MAX_DIST_RESET);
        test_orphan_points();
        test_single_points();
        test_segment_cases();
        test_limit_extremes();
        test_random_paths(600);
        test_back_to_back(110);
        wait_drained();

        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
        $display("sent %0d path points, checked %0d verdicts over %0d distance limits",
                 points_sent, verdicts_checked, limit_writes + 1);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pxc_pkg.sv
rtl/core/pxc_front.sv
rtl/core/pxc_queue.sv
rtl/core/pxc_back.sv
rtl/core/polyline_proximity_check.sv
rtl/core/pxc_checker.sv
verif/polyline_proximity_check_tb.sv
